>>> src/i2c_csrs_pkg.sv
// shared constants, mode codes and interface structs for the checksummed i2c register slave
// no dependencies

package i2c_csrs_pkg;

    // table geometry
    localparam int unsigned TABLE_DEPTH = 256;
    localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int unsigned COUNT_W     = ADDR_W + 1;

    // frame length above which a frame is a read request
    localparam int unsigned REG_COUNT   = 256;
    localparam logic [7:0]  READ_LIMIT  = 8'(REG_COUNT - 3);

    localparam logic [7:0]  SEED_RESET  = 8'h22;
    localparam logic [7:0]  IDLE_BYTE   = 8'hFF;

    // item modes
    localparam logic [2:0] MODE_ADDR_MATCH = 3'd0;
    localparam logic [2:0] MODE_BUS_WRITE  = 3'd1;
    localparam logic [2:0] MODE_BUS_READ   = 3'd2;
    localparam logic [2:0] MODE_LOCAL_LOAD = 3'd3;
    localparam logic [2:0] MODE_LOCAL_READ = 3'd4;

    // register file / mask table access
    typedef struct packed {
        logic              load_en;   // local load: value and both masks
        logic              wr_en;     // committed value write only
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic [7:0]        wr_wmask;
        logic [7:0]        wr_rmask;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } rm_req_t;

    typedef struct packed {
        logic [7:0] value;
        logic [7:0] wmask;
        logic [7:0] rmask;
    } rm_rsp_t;

    // frame buffer access
    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic [ADDR_W-1:0] rd_addr;
    } fb_req_t;

endpackage

>>> src/i2c_csrs_regmem.sv
// register file and write/read mask tables, one write and one read port, registered read
// depends on i2c_csrs_pkg

module i2c_csrs_regmem
    import i2c_csrs_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  rm_req_t req,
    output rm_rsp_t rsp
);

    logic [7:0]             value_mem [TABLE_DEPTH];
    logic [15:0]            mask_mem  [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [7:0]             value_q;
    logic [15:0]            mask_q;
    logic                   valid_q;

    // entry valid bits, an entry reads as zero until its first local load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (req.load_en)
        begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // value memory
    always_ff @(posedge clk)
    begin
        if (req.load_en || req.wr_en)
        begin
            value_mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            value_q <= value_mem[req.rd_addr];
        end
    end

    // mask memory
    always_ff @(posedge clk)
    begin
        if (req.load_en)
        begin
            mask_mem[req.wr_addr] <= {req.wr_wmask, req.wr_rmask};
        end
        if (req.rd_en)
        begin
            mask_q <= mask_mem[req.rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_q <= 1'b0;
        end
        else if (req.rd_en)
        begin
            valid_q <= valid_reg[req.rd_addr];
        end
    end

    // unloaded entries read as zero
    assign rsp.value = valid_q ? value_q      : 8'h00;
    assign rsp.wmask = valid_q ? mask_q[15:8] : 8'h00;
    assign rsp.rmask = valid_q ? mask_q[7:0]  : 8'h00;

endmodule

>>> src/i2c_csrs_fbuf.sv
// frame buffer memory holding the bytes of the current bus frame, registered read
// depends on i2c_csrs_pkg

module i2c_csrs_fbuf
    import i2c_csrs_pkg::*;
(
    input  logic       clk,
    input  fb_req_t    req,
    output logic [7:0] rd_data
);

    logic [7:0] mem [TABLE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data <= mem[req.rd_addr];
    end

endmodule

>>> src/i2c_csrs_ctrl.sv
// frame parser, checksum, commit sequencer and result register of the register slave
// depends on i2c_csrs_pkg; drives i2c_csrs_regmem and i2c_csrs_fbuf

module i2c_csrs_ctrl
    import i2c_csrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] mode,
    input  logic [7:0] bus_byte,
    input  logic [7:0] reg_address,
    input  logic [7:0] write_mask,
    input  logic [7:0] read_mask,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       ack,
    output logic [7:0] data_out,
    input  logic       cfg_valid,
    input  logic [7:0] cfg_data,
    output rm_req_t    rm_req,
    input  rm_rsp_t    rm_rsp,
    output fb_req_t    fb_req,
    input  logic [7:0] fb_rd_data
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_RDWAIT = 4'b0010,
        S_COMMIT = 4'b0100,
        S_RESP   = 4'b1000
    } state_t;

    state_t             state_reg,    state_next;
    logic [7:0]         seed_reg;
    logic [ADDR_W-1:0]  ptr_reg,      ptr_next;
    logic [COUNT_W-1:0] cnt_reg,      cnt_next;
    logic [7:0]         rcount_reg,   rcount_next;
    logic [7:0]         csum_reg,     csum_next;
    logic               armed_reg,    armed_next;
    logic [7:0]         fb0_reg,      fb0_next;
    logic [7:0]         fb1_reg,      fb1_next;
    logic [7:0]         fb2_reg,      fb2_next;
    logic               bus_rd_reg,   bus_rd_next;
    logic [7:0]         cm_len_reg,   cm_len_next;
    logic [7:0]         cm_idx_reg,   cm_idx_next;
    logic               cm_pend_reg,  cm_pend_next;
    logic [ADDR_W-1:0]  cm_waddr_reg, cm_waddr_next;
    logic               resp_ack_reg, resp_ack_next;
    logic [7:0]         resp_data_reg, resp_data_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_ack_reg,  out_ack_next;
    logic [7:0]         out_data_reg, out_data_next;

    logic               accept;
    logic               out_free;
    logic [COUNT_W-1:0] cnt_inc;
    logic [COUNT_W-1:0] rcount_end;
    logic [7:0]         len_now;
    logic [7:0]         ptr_now;
    logic [7:0]         rc_now;
    logic               read_req;
    logic [COUNT_W-1:0] expected;
    logic               cm_issue;

    assign accept     = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign cnt_inc    = cnt_reg + COUNT_W'(1);
    assign rcount_end = {1'b0, rcount_reg} + COUNT_W'(1);

    // frame header bytes, the byte on the bus overrides the one held
    assign ptr_now  = (cnt_reg[ADDR_W-1:0] == ADDR_W'(0)) ? bus_byte : fb0_reg;
    assign len_now  = (cnt_reg[ADDR_W-1:0] == ADDR_W'(1)) ? bus_byte : fb1_reg;
    assign rc_now   = (cnt_reg[ADDR_W-1:0] == ADDR_W'(2)) ? bus_byte : fb2_reg;
    assign read_req = len_now > READ_LIMIT;
    assign expected = read_req ? COUNT_W'(4) : (COUNT_W'(3) + {1'b0, len_now});
    assign cm_issue = cm_idx_reg != cm_len_reg;

    // checksum seed register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg <= SEED_RESET;
        end
        else if (cfg_valid)
        begin
            seed_reg <= cfg_data;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            cnt_reg       <= '0;
            rcount_reg    <= '0;
            csum_reg      <= '0;
            armed_reg     <= 1'b0;
            cm_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            cnt_reg       <= cnt_next;
            rcount_reg    <= rcount_next;
            csum_reg      <= csum_next;
            armed_reg     <= armed_next;
            cm_pend_reg   <= cm_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        fb0_reg       <= fb0_next;
        fb1_reg       <= fb1_next;
        fb2_reg       <= fb2_next;
        bus_rd_reg    <= bus_rd_next;
        cm_len_reg    <= cm_len_next;
        cm_idx_reg    <= cm_idx_next;
        cm_waddr_reg  <= cm_waddr_next;
        resp_ack_reg  <= resp_ack_next;
        resp_data_reg <= resp_data_next;
        out_ack_reg   <= out_ack_next;
        out_data_reg  <= out_data_next;
    end

    // next state and memory requests
    always_comb
    begin
        state_next     = state_reg;
        ptr_next       = ptr_reg;
        cnt_next       = cnt_reg;
        rcount_next    = rcount_reg;
        csum_next      = csum_reg;
        armed_next     = armed_reg;
        fb0_next       = fb0_reg;
        fb1_next       = fb1_reg;
        fb2_next       = fb2_reg;
        bus_rd_next    = bus_rd_reg;
        cm_len_next    = cm_len_reg;
        cm_idx_next    = cm_idx_reg;
        cm_pend_next   = 1'b0;
        cm_waddr_next  = cm_waddr_reg;
        resp_ack_next  = resp_ack_reg;
        resp_data_next = resp_data_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_ack_next   = out_ack_reg;
        out_data_next  = out_data_reg;

        rm_req          = '0;
        rm_req.wr_addr  = cm_waddr_reg;
        rm_req.rd_addr  = ptr_reg;
        fb_req          = '0;
        fb_req.wr_addr  = cnt_reg[ADDR_W-1:0];
        fb_req.wr_data  = bus_byte;
        fb_req.rd_addr  = ADDR_W'(cm_idx_reg) + ADDR_W'(2);

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    resp_ack_next  = 1'b1;
                    resp_data_next = 8'h00;
                    state_next     = S_RESP;
                    case (mode)
                        MODE_ADDR_MATCH:
                        begin
                            cnt_next  = '0;
                            csum_next = seed_reg;
                        end
                        MODE_BUS_WRITE:
                        begin
                            // buffer the byte and keep the header bytes at hand
                            fb_req.wr_en = 1'b1;
                            fb0_next     = ptr_now;
                            fb1_next     = len_now;
                            fb2_next     = rc_now;
                            cnt_next     = cnt_inc;
                            csum_next    = csum_reg + bus_byte;
                            if (cnt_inc >= COUNT_W'(2) && cnt_inc >= expected)
                            begin
                                // frame end: check and restart
                                cnt_next  = '0;
                                csum_next = seed_reg;
                                if (8'(~csum_reg + 8'd1) != bus_byte)
                                begin
                                    resp_ack_next = 1'b0;
                                end
                                else
                                begin
                                    ptr_next = ptr_now;
                                    if (read_req)
                                    begin
                                        armed_next  = 1'b1;
                                        rcount_next = rc_now;
                                    end
                                    else if (len_now != 8'd0)
                                    begin
                                        cm_len_next = len_now;
                                        cm_idx_next = 8'd0;
                                        state_next  = S_COMMIT;
                                    end
                                end
                            end
                        end
                        MODE_BUS_READ:
                        begin
                            if (!armed_reg || cnt_reg > rcount_end)
                            begin
                                resp_data_next = IDLE_BYTE;
                            end
                            else
                            begin
                                cnt_next = cnt_inc;
                                if (cnt_inc == rcount_end)
                                begin
                                    // checksum byte closes the read
                                    armed_next     = 1'b0;
                                    rcount_next    = 8'd0;
                                    resp_data_next = 8'(~csum_reg + 8'd1);
                                end
                                else
                                begin
                                    rm_req.rd_en   = 1'b1;
                                    rm_req.rd_addr = ptr_reg;
                                    ptr_next       = ptr_reg + ADDR_W'(1);
                                    bus_rd_next    = 1'b1;
                                    state_next     = S_RDWAIT;
                                end
                            end
                        end
                        MODE_LOCAL_LOAD:
                        begin
                            rm_req.load_en  = 1'b1;
                            rm_req.wr_addr  = reg_address;
                            rm_req.wr_data  = bus_byte;
                            rm_req.wr_wmask = write_mask;
                            rm_req.wr_rmask = read_mask;
                        end
                        MODE_LOCAL_READ:
                        begin
                            rm_req.rd_en   = 1'b1;
                            rm_req.rd_addr = reg_address;
                            bus_rd_next    = 1'b0;
                            state_next     = S_RDWAIT;
                        end
                        default:
                        begin
                            resp_ack_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RDWAIT:
            begin
                // register data has arrived
                if (bus_rd_reg)
                begin
                    resp_data_next = rm_rsp.value & rm_rsp.rmask;
                    csum_next      = csum_reg + (rm_rsp.value & rm_rsp.rmask);
                end
                else
                begin
                    resp_data_next = rm_rsp.value;
                end
                state_next = S_RESP;
            end
            S_COMMIT:
            begin
                // read entry i while merging and writing back entry i-1
                if (cm_issue)
                begin
                    rm_req.rd_en   = 1'b1;
                    rm_req.rd_addr = ptr_reg;
                    cm_waddr_next  = ptr_reg;
                    cm_pend_next   = 1'b1;
                    ptr_next       = ptr_reg + ADDR_W'(1);
                    cm_idx_next    = cm_idx_reg + 8'd1;
                end
                else
                begin
                    state_next = S_RESP;
                end
                if (cm_pend_reg)
                begin
                    rm_req.wr_en   = 1'b1;
                    rm_req.wr_addr = cm_waddr_reg;
                    rm_req.wr_data = (rm_rsp.value & ~rm_rsp.wmask) |
                                     (fb_rd_data & rm_rsp.wmask);
                end
            end
            S_RESP:
            begin
                // hand the result word to the output register
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_ack_next   = resp_ack_reg;
                    out_data_next  = resp_data_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign ack       = out_ack_reg;
    assign data_out  = out_data_reg;

endmodule

>>> src/i2c_checksummed_register_slave.sv
// top level of the checksummed i2c register slave
// depends on i2c_csrs_pkg, i2c_csrs_regmem, i2c_csrs_fbuf and i2c_csrs_ctrl

// One word in gives one result word out. Each accepted word moves to S_RESP, with
// its result held in the response register until the output register takes it;
// modes 2 and 4 first pass through S_RDWAIT when they read a register (the register
// file memory has a registered read). A write byte that closes a good write frame of
// length n commits the data bytes through the write masks one per cycle from the
// frame buffer memory, passing through S_COMMIT before S_RESP. The next word is
// taken once the result of the current one sits in the output register, so a
// stalled output holds off the next word. The seed register is written through
// cfg_valid/cfg_data and always ready; a new seed is used from the next address
// match or frame end on. After reset every register, write mask and read mask
// reads as zero until it is locally loaded; no clearing pass is needed.

module i2c_checksummed_register_slave
    import i2c_csrs_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [2:0] mode,
    input  logic [7:0] bus_byte,
    input  logic [7:0] reg_address,
    input  logic [7:0] write_mask,
    input  logic [7:0] read_mask,
    output logic       out_valid,
    input  logic       out_stall,
    output logic       ack,
    output logic [7:0] data_out,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [7:0] cfg_data
);

    rm_req_t    rm_req;
    rm_rsp_t    rm_rsp;
    fb_req_t    fb_req;
    logic [7:0] fb_rd_data;

    assign cfg_ready = 1'b1;

    // register file and masks
    i2c_csrs_regmem u_regmem (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rm_req),
        .rsp   (rm_rsp)
    );

    // frame buffer
    i2c_csrs_fbuf u_fbuf (
        .clk     (clk),
        .req     (fb_req),
        .rd_data (fb_rd_data)
    );

    // control
    i2c_csrs_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .mode        (mode),
        .bus_byte    (bus_byte),
        .reg_address (reg_address),
        .write_mask  (write_mask),
        .read_mask   (read_mask),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .ack         (ack),
        .data_out    (data_out),
        .cfg_valid   (cfg_valid && cfg_ready),
        .cfg_data    (cfg_data),
        .rm_req      (rm_req),
        .rm_rsp      (rm_rsp),
        .fb_req      (fb_req),
        .fb_rd_data  (fb_rd_data)
    );

    // one word in flight at a time
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("word accepted while previous word still in progress");

    // commit write never collides with a local load
    a_no_write_clash: assert property (@(posedge clk) disable iff (!rst_n)
        !(rm_req.wr_en && rm_req.load_en))
        else $error("commit write and local load in the same cycle");

    // pipelined commit never reads the entry it is writing back
    a_no_rmw_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        rm_req.wr_en && rm_req.rd_en |-> rm_req.wr_addr != rm_req.rd_addr)
        else $error("commit read and write hit the same register");

    // a commit write follows a commit read of the same entry
    a_commit_order: assert property (@(posedge clk) disable iff (!rst_n)
        rm_req.wr_en |-> $past(rm_req.rd_en) && $past(rm_req.rd_addr) == rm_req.wr_addr)
        else $error("commit write without matching read");

endmodule
